/* hw/rtl/trae_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trae_pkg
// Shared types and codes of the threshold rule alarm evaluator.
// ----------------------------------------------------------------------------
package trae_pkg;

  localparam int DEVICE_W   = 8;
  localparam int VALUE_W    = 32;
  localparam int RULE_SLOTS = 4;
  localparam int CONDITIONS = 4;
  localparam int DEVICES    = 256;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VERDICT_W  = 3;
  localparam int IN_DATA_W  = DEVICE_W + RULE_SLOTS * VALUE_W;
  localparam int OUT_DATA_W = 16;

  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE_CONTROL = 3'd0,
    REG_COMPARE_OPS  = 3'd1,
    REG_LINK_OPS     = 3'd2,
    REG_THRESHOLD_0  = 3'd3,
    REG_THRESHOLD_1  = 3'd4,
    REG_THRESHOLD_2  = 3'd5,
    REG_THRESHOLD_3  = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    CMP_GT = 3'd0,
    CMP_GE = 3'd1,
    CMP_LT = 3'd2,
    CMP_LE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_op_t;

  typedef enum logic [1:0] {
    LINK_END   = 2'd0,
    LINK_AND   = 2'd1,
    LINK_OR    = 2'd2,
    LINK_SPLIT = 2'd3
  } link_op_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FALSE     = 3'd0,
    VERDICT_TRUE      = 3'd1,
    VERDICT_RUN_START = 3'd2,
    VERDICT_RUN_STOP  = 3'd3,
    VERDICT_DISABLED  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [3:0]                   rule_control;
    logic [3*RULE_SLOTS-1:0]      compare_ops;
    logic [2*RULE_SLOTS-1:0]      link_ops;
    value_t [RULE_SLOTS-1:0]      thresholds;
  } rule_cfg_t;

  typedef struct packed {
    logic enable;
    logic run_mode;
    logic normal_res;
    logic start_res;
    logic stop_res;
  } eval_res_t;

endpackage
`default_nettype wire

/* hw/rtl/trae_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trae_cfg_regs
// Rule configuration registers behind the plain write port.
// ----------------------------------------------------------------------------
module trae_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [trae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trae_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output trae_pkg::rule_cfg_t                  cfg
);
  import trae_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_RULE_CONTROL: cfg.rule_control  <= cfg_wdata[3:0];
        REG_COMPARE_OPS:  cfg.compare_ops   <= cfg_wdata[3*RULE_SLOTS-1:0];
        REG_LINK_OPS:     cfg.link_ops      <= cfg_wdata[2*RULE_SLOTS-1:0];
        REG_THRESHOLD_0:  cfg.thresholds[0] <= cfg_wdata[VALUE_W-1:0];
        REG_THRESHOLD_1:  cfg.thresholds[1] <= cfg_wdata[VALUE_W-1:0];
        REG_THRESHOLD_2:  cfg.thresholds[2] <= cfg_wdata[VALUE_W-1:0];
        REG_THRESHOLD_3:  cfg.thresholds[3] <= cfg_wdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/trae_rule_eval.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trae_rule_eval
// Threshold comparators and the chained rule groups, purely combinational.
// ----------------------------------------------------------------------------
module trae_rule_eval (
  input  wire trae_pkg::rule_cfg_t                        cfg,
  input  wire trae_pkg::value_t [trae_pkg::RULE_SLOTS-1:0] values,
  output trae_pkg::eval_res_t                             res
);
  import trae_pkg::*;

  logic [RULE_SLOTS-1:0] hit;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      split;
  logic                  split_found;
  logic [CNT_W-1:0]      start_last;
  logic [CNT_W-1:0]      stop_first;

  function automatic logic eval_group(input logic [RULE_SLOTS-1:0]   r,
                                      input logic [2*RULE_SLOTS-1:0] links,
                                      input logic [CNT_W-1:0]        first,
                                      input logic [CNT_W-1:0]        last,
                                      input logic                    normal);
    logic cur;
    logic done;
    logic outcome;
    cur     = 1'b0;
    done    = 1'b0;
    outcome = 1'b0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (!done && (CNT_W'(i) >= first) && (CNT_W'(i) < last)) begin
        cur = r[i];
        case (link_op_t'(links[2*i +: 2]))
          LINK_AND: begin
            if (!cur) begin
              outcome = 1'b0;
              done    = 1'b1;
            end
          end
          LINK_OR: begin
            if (cur) begin
              outcome = 1'b1;
              done    = 1'b1;
            end
          end
          LINK_SPLIT: begin
            if (normal) begin
              if (cur) begin
                outcome = 1'b1;
                done    = 1'b1;
              end
            end else begin
              outcome = cur;
              done    = 1'b1;
            end
          end
          default: begin
            outcome = cur;
            done    = 1'b1;
          end
        endcase
      end
    end
    if (!done) begin
      outcome = cur;
    end
    return outcome;
  endfunction

  always_comb begin
    for (int i = 0; i < RULE_SLOTS; i++) begin
      case (cmp_op_t'(cfg.compare_ops[3*i +: 3]))
        CMP_GT:  hit[i] = $signed(values[i]) >  $signed(cfg.thresholds[i]);
        CMP_GE:  hit[i] = $signed(values[i]) >= $signed(cfg.thresholds[i]);
        CMP_LT:  hit[i] = $signed(values[i]) <  $signed(cfg.thresholds[i]);
        CMP_LE:  hit[i] = $signed(values[i]) <= $signed(cfg.thresholds[i]);
        CMP_EQ:  hit[i] = values[i] == cfg.thresholds[i];
        CMP_NE:  hit[i] = values[i] != cfg.thresholds[i];
        default: hit[i] = 1'b0;
      endcase
    end
  end

  always_comb begin
    cnt = CNT_W'(cfg.rule_control[3:2]) + CNT_W'(1);
    if (cnt > CNT_W'(CONDITIONS)) begin
      cnt = CNT_W'(CONDITIONS);
    end
    split       = cnt;
    split_found = 1'b0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (!split_found && (CNT_W'(i) < cnt) &&
          (link_op_t'(cfg.link_ops[2*i +: 2]) == LINK_SPLIT)) begin
        split       = CNT_W'(i);
        split_found = 1'b1;
      end
    end
    start_last = split_found ? split + CNT_W'(1) : cnt;
    stop_first = split + CNT_W'(1);
  end

  always_comb begin
    res.enable     = cfg.rule_control[0];
    res.run_mode   = cfg.rule_control[1];
    res.normal_res = eval_group(hit, cfg.link_ops, '0, cnt, 1'b1);
    res.start_res  = eval_group(hit, cfg.link_ops, '0, start_last, 1'b0);
    res.stop_res   = (split_found && (stop_first < cnt)) ?
                     eval_group(hit, cfg.link_ops, stop_first, cnt, 1'b0) : 1'b0;
  end

endmodule
`default_nettype wire

/* hw/rtl/trae_run_flags.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trae_run_flags
// Per-device run flags and the verdict decision with flag update.
// ----------------------------------------------------------------------------
module trae_run_flags #(
  parameter int DEVICES = trae_pkg::DEVICES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [trae_pkg::DEVICE_W-1:0] load_device,
  input  wire logic                          advance,
  input  wire logic [trae_pkg::DEVICE_W-1:0] device,
  input  wire trae_pkg::eval_res_t           res,
  output logic                               busy,
  output trae_pkg::verdict_t                 verdict
);
  import trae_pkg::*;

  localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  logic             flags [DEVICES];
  logic [IDX_W-1:0] clear_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] idx;
  logic             flag_rd;
  logic             in_range;
  logic             flag;
  logic             wr_en;
  logic             wr_val;
  logic             wr_fire;

  assign rd_idx  = IDX_W'(load_device);
  assign wr_fire = advance && wr_en;

  always_comb begin
    idx      = IDX_W'(device);
    in_range = 32'(device) < 32'(DEVICES);
    flag     = in_range ? flag_rd : 1'b0;
    wr_en    = 1'b0;
    wr_val   = 1'b0;
    if (!res.enable) begin
      verdict = VERDICT_DISABLED;
    end else if (!res.run_mode) begin
      verdict = res.normal_res ? VERDICT_TRUE : VERDICT_FALSE;
    end else if (res.start_res && !res.stop_res && !flag) begin
      verdict = VERDICT_RUN_START;
      wr_en   = in_range;
      wr_val  = 1'b1;
    end else if (!res.start_res && res.stop_res && flag) begin
      verdict = VERDICT_RUN_STOP;
      wr_en   = in_range;
      wr_val  = 1'b0;
    end else begin
      verdict = VERDICT_FALSE;
    end
  end

  // sweep every entry to stopped after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clear_idx <= '0;
    end else if (busy) begin
      clear_idx <= clear_idx + IDX_W'(1);
      if (clear_idx == IDX_W'(DEVICES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      flags[clear_idx] <= 1'b0;
    end else if (wr_fire) begin
      flags[idx] <= wr_val;
    end
  end

  // read on accept; forward the write of the item ahead
  always_ff @(posedge clk) begin
    if (load) begin
      if (wr_fire && (idx == rd_idx)) begin
        flag_rd <= wr_val;
      end else begin
        flag_rd <= flags[rd_idx];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/threshold_rule_alarm_evaluator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_rule_alarm_evaluator
// Evaluates a configured threshold rule on each measurement item.
//
// Items enter on the s_ stream (device and four values) and one verdict item
// per input leaves on the m_ stream. The rule sits in seven registers
// written through cfg_wen/cfg_index/cfg_wdata. The user must write them
// only while the block is idle; the block does not enforce it. An accepted
// item enters the input register; once the result side is free its verdict
// is loaded into the result register, which drives m_tvalid. Throughput is
// one item per cycle while m_tready is high; the run flag of a device is
// read when its item is accepted and the write of the item ahead is
// forwarded, so consecutive items on one device see the updated flag. When
// m_tready is low a valid result holds and an empty input register takes one
// more item before s_tready drops. Reset clears the configuration and both
// valid bits; s_tready stays low while a clearing pass stops every run flag.
// ----------------------------------------------------------------------------
module threshold_rule_alarm_evaluator #(
  parameter int DEVICES = trae_pkg::DEVICES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // device[7:0], value_0[39:8], value_1[71:40], value_2[103:72], value_3[135:104]
  input  wire logic [trae_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // device_echo[7:0], verdict[10:8], zero[15:11]
  output logic [trae_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                            cfg_wen,
  input  wire logic [trae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trae_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import trae_pkg::*;

  rule_cfg_t               cfg;
  eval_res_t               res;
  verdict_t                verdict_comb;

  logic                    in_valid;
  logic [DEVICE_W-1:0]     in_device;
  value_t [RULE_SLOTS-1:0] in_values;

  logic                    out_valid;
  logic [DEVICE_W-1:0]     device_echo;
  verdict_t                verdict;

  logic                    out_load;
  logic                    advance;
  logic                    in_load;
  logic                    flags_busy;

  assign out_load = !out_valid || m_tready;
  assign advance  = in_valid && out_load;
  assign s_tready = !flags_busy && (!in_valid || out_load);
  assign in_load  = s_tready && s_tvalid;

  trae_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trae_rule_eval u_eval (
    .cfg    (cfg),
    .values (in_values),
    .res    (res)
  );

  trae_run_flags #(
    .DEVICES (DEVICES)
  ) u_flags (
    .clk         (clk),
    .rst         (rst),
    .load        (in_load),
    .load_device (s_tdata[DEVICE_W-1:0]),
    .advance     (advance),
    .device      (in_device),
    .res         (res),
    .busy        (flags_busy),
    .verdict     (verdict_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_device <= s_tdata[DEVICE_W-1:0];
      for (int i = 0; i < RULE_SLOTS; i++) begin
        in_values[i] <= s_tdata[DEVICE_W + i*VALUE_W +: VALUE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      device_echo <= in_device;
      verdict     <= verdict_comb;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - DEVICE_W - VERDICT_W)'(0), verdict, device_echo};

endmodule
`default_nettype wire

/* dv/alarm_verdict_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_verdict_checker
// Watches the rule register port and both item streams of the threshold rule
// alarm evaluator. It keeps its own copy of the rule and of the per-device run
// flags, predicts the verdict of every accepted input item, and compares each
// result item in order against the oldest prediction.
// ----------------------------------------------------------------------------
module alarm_verdict_checker
  import trae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending
);

  typedef struct {
    logic [DEVICE_W-1:0] device;
    verdict_t            verdict;
  } verdict_item_t;

  verdict_item_t            expected_verdicts[$];
  logic [3:0]               rule_control;
  logic [3*RULE_SLOTS-1:0]  compare_sel;
  logic [2*RULE_SLOTS-1:0]  link_sel;
  value_t                   thresholds[RULE_SLOTS];
  logic                     run_flags[DEVICES];

  function automatic logic cond_hit(logic [2:0] code, value_t value, value_t thr);
    case (code)
      CMP_GT:  return $signed(value) > $signed(thr);
      CMP_GE:  return $signed(value) >= $signed(thr);
      CMP_LT:  return $signed(value) < $signed(thr);
      CMP_LE:  return $signed(value) <= $signed(thr);
      CMP_EQ:  return value == thr;
      CMP_NE:  return value != thr;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic chain_group(logic [RULE_SLOTS-1:0] hit, int first, int last,
                                       logic normal);
    logic     cur;
    link_op_t lk;
    cur = 1'b0;
    for (int i = first; i < last; i++) begin
      lk  = link_op_t'(link_sel[2*i +: 2]);
      cur = hit[i];
      if (lk == LINK_AND) begin
        if (!cur) return 1'b0;
      end else if (lk == LINK_OR || (lk == LINK_SPLIT && normal)) begin
        if (cur) return 1'b1;
      end else begin
        return cur;
      end
    end
    return cur;
  endfunction

  function automatic verdict_t predict_verdict(logic [IN_DATA_W-1:0] item);
    logic [RULE_SLOTS-1:0] hit;
    logic [DEVICE_W-1:0]   dev;
    int                    count;
    int                    split;
    logic                  start_res;
    logic                  stop_res;
    logic                  flag;
    logic                  in_range;
    verdict_t              verdict;
    dev = item[DEVICE_W-1:0];
    if (!rule_control[0]) return VERDICT_DISABLED;
    count = int'(rule_control[3:2]) + 1;
    if (count > CONDITIONS) count = CONDITIONS;
    if (count > RULE_SLOTS) count = RULE_SLOTS;
    for (int k = 0; k < RULE_SLOTS; k++) begin
      hit[k] = cond_hit(compare_sel[3*k +: 3], item[DEVICE_W + VALUE_W*k +: VALUE_W],
                        thresholds[k]);
    end
    if (!rule_control[1]) return chain_group(hit, 0, count, 1'b1) ? VERDICT_TRUE : VERDICT_FALSE;
    // first group mark inside the count splits start from stop
    split = count;
    for (int k = count - 1; k >= 0; k--) begin
      if (link_sel[2*k +: 2] == LINK_SPLIT) split = k;
    end
    if (split < count) begin
      start_res = chain_group(hit, 0, split + 1, 1'b0);
      stop_res  = (split + 1 < count) ? chain_group(hit, split + 1, count, 1'b0) : 1'b0;
    end else begin
      start_res = chain_group(hit, 0, count, 1'b0);
      stop_res  = 1'b0;
    end
    in_range = int'(dev) < DEVICES;
    flag     = in_range ? run_flags[dev] : 1'b0;
    verdict  = VERDICT_FALSE;
    if (start_res && !stop_res && !flag) begin
      if (in_range) run_flags[dev] = 1'b1;
      verdict = VERDICT_RUN_START;
    end else if (!start_res && stop_res && flag) begin
      if (in_range) run_flags[dev] = 1'b0;
      verdict = VERDICT_RUN_STOP;
    end
    return verdict;
  endfunction

  always @(posedge clk) begin
    verdict_item_t want;
    verdict_item_t got;
    if (rst) begin
      rule_control = '0;
      compare_sel  = '0;
      link_sel     = '0;
      foreach (thresholds[k]) thresholds[k] = '0;
      foreach (run_flags[d]) run_flags[d] = 1'b0;
      expected_verdicts.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_RULE_CONTROL: rule_control  = cfg_wdata[3:0];
          REG_COMPARE_OPS:  compare_sel   = cfg_wdata[3*RULE_SLOTS-1:0];
          REG_LINK_OPS:     link_sel      = cfg_wdata[2*RULE_SLOTS-1:0];
          REG_THRESHOLD_0:  thresholds[0] = cfg_wdata;
          REG_THRESHOLD_1:  thresholds[1] = cfg_wdata;
          REG_THRESHOLD_2:  thresholds[2] = cfg_wdata;
          REG_THRESHOLD_3:  thresholds[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.device  = m_tdata[DEVICE_W-1:0];
        got.verdict = verdict_t'(m_tdata[DEVICE_W +: VERDICT_W]);
        if (expected_verdicts.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result item device=%0d verdict=%0d",
                     $realtime, got.device, got.verdict);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.device !== want.device || got.verdict !== want.verdict) begin
            if (mismatch_count < 10)
              $display("%0t: result mismatch device exp=%0d got=%0d, verdict exp=%0d got=%0d",
                       $realtime, want.device, got.device, want.verdict, got.verdict);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want.device  = s_tdata[DEVICE_W-1:0];
        want.verdict = predict_verdict(s_tdata);
        expected_verdicts.push_back(want);
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

/* dv/tb_threshold_rule_alarm_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_rule_alarm_evaluator
// Stimulus and verdict for the threshold rule alarm evaluator.
//
// A directed pass walks the reset rule, every compare and link code, the
// extreme values and the run start and stop cases; random rules with values
// clustered around their thresholds follow. Both streams idle at random, the
// result side holds off once for a long stretch, and the rule is only rewritten
// once every result has come back. The checker instance does the comparing.
// ----------------------------------------------------------------------------
module tb_threshold_rule_alarm_evaluator;
  import trae_pkg::*;

  localparam int         TOTAL_ITEMS    = 1250;
  localparam logic [2:0] CMP_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMP_RESERVED_7 = 3'd7;
  localparam value_t     VAL_MAX        = 32'h7FFF_FFFF;
  localparam value_t     VAL_MIN        = 32'h8000_0000;
  localparam value_t     MINUS_ONE      = 32'hFFFF_FFFF;
  localparam value_t     MILLI          = 32'd1000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    pending;
  int                    sent_count;
  bit                    hold_done;
  wire                   steady = (sent_count >= 700) && (sent_count < 900);

  threshold_rule_alarm_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alarm_verdict_checker verdicts (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 400) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic send_sample(input logic [DEVICE_W-1:0] dev, input value_t v0, input value_t v1,
                             input value_t v2, input value_t v3);
    while (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v3, v2, v1, v0, dev};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_rule(input rule_cfg_t r);
    drain_results();
    write_reg(REG_RULE_CONTROL, CFG_DATA_W'(r.rule_control));
    write_reg(REG_COMPARE_OPS, CFG_DATA_W'(r.compare_ops));
    write_reg(REG_LINK_OPS, CFG_DATA_W'(r.link_ops));
    write_reg(REG_THRESHOLD_0, r.thresholds[0]);
    write_reg(REG_THRESHOLD_1, r.thresholds[1]);
    write_reg(REG_THRESHOLD_2, r.thresholds[2]);
    write_reg(REG_THRESHOLD_3, r.thresholds[3]);
    cfg_wen <= 1'b0;
  endtask

  function automatic value_t pick_threshold();
    case ($urandom_range(5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return value_t'($urandom_range(4000)) - 2000;
      default: return $urandom();
    endcase
  endfunction

  function automatic value_t pick_value(value_t thr);
    case ($urandom_range(9))
      0, 1, 2: return thr + value_t'($urandom_range(2)) - 1;
      3, 4:    return thr + value_t'($urandom_range(20000)) - 10000;
      5:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return $urandom();
    endcase
  endfunction

  function automatic rule_cfg_t random_rule();
    rule_cfg_t r;
    r.rule_control = 4'($urandom());
    if ($urandom_range(9) != 0) r.rule_control[0] = 1'b1;
    for (int k = 0; k < RULE_SLOTS; k++) begin
      r.compare_ops[3*k +: 3] = ($urandom_range(99) < 85) ? 3'($urandom_range(5))
                                                           : 3'($urandom_range(7));
      r.link_ops[2*k +: 2]    = 2'($urandom());
      r.thresholds[k]         = pick_threshold();
    end
    return r;
  endfunction

  initial begin
    rule_cfg_t           rule;
    int                  burst;
    logic [DEVICE_W-1:0] dev;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    cfg_wen    <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    sent_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset rule is disabled
    send_sample(8'hFF, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_sample(8'h00, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);

    // normal mode, ordering compares, group mark behaves like or
    rule.rule_control = 4'b1101;
    rule.compare_ops  = {CMP_LE, CMP_LT, CMP_GE, CMP_GT};
    rule.link_ops     = {LINK_END, LINK_SPLIT, LINK_OR, LINK_AND};
    rule.thresholds   = {MINUS_ONE, VAL_MAX, VAL_MIN, value_t'(0)};
    apply_rule(rule);
    send_sample(8'hFF, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_sample(8'h00, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
    send_sample(8'hA5, '0, '0, '0, '0);
    send_sample(8'h5A, value_t'(1), VAL_MIN, VAL_MAX, MINUS_ONE);

    // equality compares and reserved codes over three conditions
    rule.rule_control = 4'b1001;
    rule.compare_ops  = {CMP_RESERVED_7, CMP_RESERVED_6, CMP_NE, CMP_EQ};
    rule.link_ops     = {LINK_OR, LINK_END, LINK_AND, LINK_AND};
    rule.thresholds   = {MILLI, MILLI, MILLI, MILLI};
    apply_rule(rule);
    send_sample(8'h01, MILLI, MILLI, MILLI, MILLI);
    send_sample(8'h02, MILLI, MILLI - 1, MILLI, MILLI);
    send_sample(8'h03, MILLI - 1, MILLI + 1, MILLI, MILLI);
    send_sample(8'h04, MILLI, MILLI + 1, MILLI, MILLI);

    // run mode with start and stop groups
    rule.rule_control = 4'b1111;
    rule.compare_ops  = {CMP_LT, CMP_LT, CMP_GE, CMP_GE};
    rule.link_ops     = {LINK_END, LINK_OR, LINK_SPLIT, LINK_AND};
    rule.thresholds   = '0;
    apply_rule(rule);
    send_sample(8'h03, value_t'(1), value_t'(1), value_t'(1), value_t'(1));
    send_sample(8'h03, value_t'(1), value_t'(1), value_t'(1), value_t'(1));
    send_sample(8'h03, MINUS_ONE, MINUS_ONE, MINUS_ONE, MINUS_ONE);
    send_sample(8'h03, MINUS_ONE, value_t'(1), MINUS_ONE, value_t'(1));
    send_sample(8'h03, value_t'(1), value_t'(1), MINUS_ONE, value_t'(1));
    send_sample(8'h04, value_t'(1), value_t'(1), value_t'(1), value_t'(1));

    // run mode, no group mark within the count
    rule.rule_control = 4'b0111;
    rule.compare_ops  = {CMP_GT, CMP_GT, CMP_GT, CMP_GT};
    rule.link_ops     = {LINK_SPLIT, LINK_OR, LINK_OR, LINK_OR};
    apply_rule(rule);
    send_sample(8'h09, value_t'(1), '0, '0, '0);
    send_sample(8'h09, '0, '0, '0, '0);

    // run mode, group mark on the last counted condition
    rule.rule_control = 4'b1011;
    rule.compare_ops  = {CMP_NE, CMP_NE, CMP_NE, CMP_NE};
    rule.link_ops     = {LINK_AND, LINK_SPLIT, LINK_AND, LINK_AND};
    rule.thresholds   = {MILLI, MILLI, MILLI, MILLI};
    apply_rule(rule);
    send_sample(8'h0A, '0, '0, '0, '0);
    send_sample(8'h0A, '0, '0, '0, '0);

    while (sent_count < TOTAL_ITEMS) begin
      rule = random_rule();
      apply_rule(rule);
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        dev = ($urandom_range(3) != 0) ? DEVICE_W'($urandom_range(7)) : DEVICE_W'($urandom());
        send_sample(dev, pick_value(rule.thresholds[0]), pick_value(rule.thresholds[1]),
                    pick_value(rule.thresholds[2]), pick_value(rule.thresholds[3]));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
